### rtl/c_like_token_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// C-like token classifier: assertion macros
// Shared helpers for the concurrent checks of the classifier core.
// ----------------------------------------------------------------------------
`ifndef C_LIKE_TOKEN_CLASSIFIER_CORE_DEFINES_SVH
`define C_LIKE_TOKEN_CLASSIFIER_CORE_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define CTLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that holds in the cycle after its condition.
`define CTLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ctlc_pkg.sv
// ----------------------------------------------------------------------------
// C-like token classifier package
// Shared widths, codes and record types of the classifier core.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlc_pkg;

    // Widths of characters and span positions.
    localparam int unsigned CHAR_W = 16;
    localparam int unsigned POS_W  = 32;

    // Queue depths; both must be powers of two.
    localparam int unsigned ITEM_QUEUE_DEPTH = 2;
    localparam int unsigned RES_QUEUE_DEPTH  = 4;

    // Reset value of the annotation character ('#').
    localparam logic [CHAR_W-1:0] ANNOT_RESET = 16'h0023;

    // Span classes as reported on the result side.
    typedef enum logic [2:0] {
        CL_GAP     = 3'd0,
        CL_COMMENT = 3'd1,
        CL_OPER    = 3'd2,
        CL_STRING  = 3'd3,
        CL_WORD    = 3'd4
    } token_class_t;

    // Word prefix marks.
    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_SHARP = 2'd1,
        PFX_ANNOT = 2'd2
    } prefix_t;

    // Character classes decoded by the front end.
    typedef enum logic [3:0] {
        CC_NL,
        CC_BLANK,
        CC_SHARP,
        CC_STAR,
        CC_SLASH,
        CC_DQUOTE,
        CC_SQUOTE,
        CC_BSLASH,
        CC_WORD,
        CC_OTHER
    } char_class_t;

    // Decoded request passed from the front end to the lexer.
    typedef struct packed {
        char_class_t cc;
        logic        annot;
        logic        flush;
    } item_t;

    // One result record.
    typedef struct packed {
        token_class_t       token_class;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
        logic [POS_W-1:0]   word_begin;
        prefix_t            prefix_kind;
        logic               partial;
        logic               last;
    } res_t;

    // Up to two results written by the lexer in one cycle.
    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } res_wr_t;

endpackage

`default_nettype wire

### rtl/ctlc_front.sv
// ----------------------------------------------------------------------------
// C-like token classifier: front end
// Holds the annotation character and decodes each character into a class.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlc_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         annotation_char_we,
    input  wire logic [ctlc_pkg::CHAR_W-1:0]  annotation_char,
    input  wire logic [ctlc_pkg::CHAR_W-1:0]  code_unit,
    input  wire logic                         flush,
    output ctlc_pkg::item_t                   item
);

    logic [ctlc_pkg::CHAR_W-1:0] annot_reg;

    // Map a character to the class the lexer acts on.
    function automatic ctlc_pkg::char_class_t classify(input logic [ctlc_pkg::CHAR_W-1:0] c);
        ctlc_pkg::char_class_t cc;
        case (c) inside
            16'h000A:                   cc = ctlc_pkg::CC_NL;
            16'h0009, 16'h0020:         cc = ctlc_pkg::CC_BLANK;
            16'h0023:                   cc = ctlc_pkg::CC_SHARP;
            16'h002A:                   cc = ctlc_pkg::CC_STAR;
            16'h002F:                   cc = ctlc_pkg::CC_SLASH;
            16'h0022:                   cc = ctlc_pkg::CC_DQUOTE;
            16'h0027:                   cc = ctlc_pkg::CC_SQUOTE;
            16'h005C:                   cc = ctlc_pkg::CC_BSLASH;
            [16'h0030:16'h0039],
            [16'h0041:16'h005A],
            [16'h0061:16'h007A],
            16'h005F,
            [16'h0080:16'hFFFF]:        cc = ctlc_pkg::CC_WORD;
            default:                    cc = ctlc_pkg::CC_OTHER;
        endcase
        return cc;
    endfunction

    // Annotation character register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            annot_reg <= ctlc_pkg::ANNOT_RESET;
        end
        else if (annotation_char_we)
        begin
            annot_reg <= annotation_char;
        end
    end

    // Decoded request towards the item queue.
    always_comb
    begin
        item.cc    = classify(code_unit);
        item.annot = (code_unit == annot_reg);
        item.flush = flush;
    end

endmodule

`default_nettype wire

### rtl/ctlc_item_queue.sv
// ----------------------------------------------------------------------------
// C-like token classifier: item queue
// Short queue of decoded requests between the front end and the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlc_item_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ctlc_pkg::item_t wr_item,
    output logic                 full,
    input  wire logic            pop,
    output ctlc_pkg::item_t      rd_item,
    output logic                 empty
);

    localparam int unsigned DEPTH = ctlc_pkg::ITEM_QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ctlc_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

### rtl/ctlc_lexer.sv
// ----------------------------------------------------------------------------
// C-like token classifier: lexer
// Runs the lexer state machine on one decoded request per cycle while the
// result queue has room, and writes up to two finished spans into it.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlc_lexer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ctlc_pkg::item_t item,
    input  wire logic            item_empty,
    output logic                 item_pop,
    input  wire logic            res_room,
    output ctlc_pkg::res_wr_t    res_wr
);

    localparam int unsigned POS_W = ctlc_pkg::POS_W;

    typedef enum logic [3:0] {
        M_STARTLINE  = 4'd0,
        M_ANNOT      = 4'd1,
        M_BLOCK      = 4'd2,
        M_BLOCK_STAR = 4'd3,
        M_DQ         = 4'd4,
        M_DQ_ESC     = 4'd5,
        M_LINE       = 4'd6,
        M_LINE_ESC   = 4'd7,
        M_NORMAL     = 4'd8,
        M_SQ         = 4'd9,
        M_SQ_ESC     = 4'd10,
        M_SHARP      = 4'd11,
        M_SLASH      = 4'd12,
        M_WORD       = 4'd13
    } mode_t;

    typedef struct packed {
        mode_t                  mode;
        logic [POS_W-1:0]       span_start;
        logic [POS_W-1:0]       body_start;
        ctlc_pkg::token_class_t open_class;
        ctlc_pkg::prefix_t      open_prefix;
    } lex_state_t;

    typedef struct packed {
        lex_state_t     st;
        logic           retry;
        logic           gap_v;
        logic           close_v;
        ctlc_pkg::res_t gap_res;
        ctlc_pkg::res_t close_res;
    } pass_t;

    localparam lex_state_t STATE_RESET = '{
        mode:        M_STARTLINE,
        span_start:  '0,
        body_start:  '0,
        open_class:  ctlc_pkg::CL_GAP,
        open_prefix: ctlc_pkg::PFX_NONE
    };

    lex_state_t        state_reg;
    lex_state_t        state_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    pass_t             pass1;
    pass_t             pass2;
    ctlc_pkg::res_t    slot   [4];
    logic [3:0]        slot_v;

    // Build a result record; word fields are zero for every class but word.
    function automatic ctlc_pkg::res_t make_res(
        input ctlc_pkg::token_class_t cls,
        input logic [POS_W-1:0]       s,
        input logic [POS_W-1:0]       e,
        input logic [POS_W-1:0]       b,
        input ctlc_pkg::prefix_t      pf,
        input logic                   part
    );
        ctlc_pkg::res_t r;
        r.token_class = cls;
        r.start_pos   = s;
        r.end_pos     = e;
        r.word_begin  = (cls == ctlc_pkg::CL_WORD) ? b : '0;
        r.prefix_kind = (cls == ctlc_pkg::CL_WORD) ? pf : ctlc_pkg::PFX_NONE;
        r.partial     = part;
        r.last        = 1'b0;
        return r;
    endfunction

    // State left behind when the open span closes at position e.
    function automatic lex_state_t closed_state(input logic [POS_W-1:0] e, input logic is_nl);
        lex_state_t s;
        s.mode        = is_nl ? M_STARTLINE : M_NORMAL;
        s.span_start  = e;
        s.body_start  = '0;
        s.open_class  = ctlc_pkg::CL_GAP;
        s.open_prefix = ctlc_pkg::PFX_NONE;
        return s;
    endfunction

    // One pass of the state machine over the character at position p.
    function automatic pass_t lex_pass(
        input lex_state_t       s,
        input ctlc_pkg::item_t  it,
        input logic [POS_W-1:0] p
    );
        pass_t            r;
        logic [POS_W-1:0] nxt;
        logic             is_nl;
        nxt   = p + 1'b1;
        is_nl = (it.cc == ctlc_pkg::CC_NL);
        r           = '0;
        r.st        = s;
        r.gap_res   = make_res(ctlc_pkg::CL_GAP, s.span_start, p, '0, ctlc_pkg::PFX_NONE, 1'b0);
        r.close_res = make_res(s.open_class, s.span_start, p, s.body_start, s.open_prefix, 1'b0);
        case (s.mode)
            M_STARTLINE:
            begin
                if (it.cc == ctlc_pkg::CC_NL || it.cc == ctlc_pkg::CC_BLANK)
                begin
                    r.st = s;
                end
                else if (it.cc == ctlc_pkg::CC_SHARP)
                begin
                    r.gap_v          = (s.span_start != p);
                    r.st.span_start  = p;
                    r.st.open_class  = ctlc_pkg::CL_WORD;
                    r.st.open_prefix = ctlc_pkg::PFX_SHARP;
                    r.st.body_start  = nxt;
                    r.st.mode        = M_SHARP;
                end
                else
                begin
                    r.st.mode = M_NORMAL;
                    r.retry   = 1'b1;
                end
            end
            M_ANNOT:
            begin
                if (it.cc == ctlc_pkg::CC_WORD)
                begin
                    r.st.open_class  = ctlc_pkg::CL_WORD;
                    r.st.open_prefix = ctlc_pkg::PFX_ANNOT;
                    r.st.body_start  = p;
                    r.st.mode        = M_WORD;
                end
                else
                begin
                    r.st.mode = M_NORMAL;
                    r.retry   = 1'b1;
                end
            end
            M_BLOCK:
            begin
                if (it.cc == ctlc_pkg::CC_STAR)
                begin
                    r.st.mode = M_BLOCK_STAR;
                end
            end
            M_BLOCK_STAR:
            begin
                if (it.cc == ctlc_pkg::CC_SLASH)
                begin
                    r.close_v           = 1'b1;
                    r.close_res.end_pos = nxt;
                    r.st                = closed_state(nxt, is_nl);
                end
                else if (it.cc != ctlc_pkg::CC_STAR)
                begin
                    r.st.mode = M_BLOCK;
                end
            end
            M_DQ:
            begin
                if (it.cc == ctlc_pkg::CC_DQUOTE)
                begin
                    r.close_v           = 1'b1;
                    r.close_res.end_pos = nxt;
                    r.st                = closed_state(nxt, is_nl);
                end
                else if (it.cc == ctlc_pkg::CC_BSLASH)
                begin
                    r.st.mode = M_DQ_ESC;
                end
            end
            M_DQ_ESC:
            begin
                r.st.mode = M_DQ;
            end
            M_SQ:
            begin
                if (it.cc == ctlc_pkg::CC_SQUOTE)
                begin
                    r.close_v           = 1'b1;
                    r.close_res.end_pos = nxt;
                    r.st                = closed_state(nxt, is_nl);
                end
                else if (it.cc == ctlc_pkg::CC_BSLASH)
                begin
                    r.st.mode = M_SQ_ESC;
                end
            end
            M_SQ_ESC:
            begin
                r.st.mode = M_SQ;
            end
            M_LINE:
            begin
                if (is_nl)
                begin
                    r.close_v = 1'b1;
                    r.st      = closed_state(p, is_nl);
                    r.retry   = 1'b1;
                end
                else if (it.cc == ctlc_pkg::CC_BSLASH)
                begin
                    r.st.mode = M_LINE_ESC;
                end
            end
            M_LINE_ESC:
            begin
                r.st.mode = M_LINE;
            end
            M_SHARP:
            begin
                if (is_nl)
                begin
                    r.st.open_class  = ctlc_pkg::CL_GAP;
                    r.st.open_prefix = ctlc_pkg::PFX_NONE;
                    r.st.body_start  = '0;
                    r.st.mode        = M_STARTLINE;
                end
                else if (it.cc == ctlc_pkg::CC_BLANK)
                begin
                    r.st = s;
                end
                else if (it.cc == ctlc_pkg::CC_WORD)
                begin
                    r.st.body_start = p;
                    r.st.mode       = M_WORD;
                end
                else
                begin
                    r.st.open_class  = ctlc_pkg::CL_GAP;
                    r.st.open_prefix = ctlc_pkg::PFX_NONE;
                    r.st.body_start  = '0;
                    r.st.mode        = M_NORMAL;
                end
            end
            M_SLASH:
            begin
                if (it.cc == ctlc_pkg::CC_SLASH)
                begin
                    r.st.open_class = ctlc_pkg::CL_COMMENT;
                    r.st.mode       = M_LINE;
                end
                else if (it.cc == ctlc_pkg::CC_STAR)
                begin
                    r.st.open_class = ctlc_pkg::CL_COMMENT;
                    r.st.mode       = M_BLOCK;
                end
                else
                begin
                    r.close_v = 1'b1;
                    r.st      = closed_state(p, is_nl);
                    r.retry   = 1'b1;
                end
            end
            M_WORD:
            begin
                if (it.cc != ctlc_pkg::CC_WORD)
                begin
                    r.close_v = 1'b1;
                    r.st      = closed_state(p, is_nl);
                    r.retry   = 1'b1;
                end
            end
            default:
            begin
                // Normal mode: blanks pass, a newline goes to line start, anything else opens a new span.
                if (is_nl)
                begin
                    r.st.mode = M_STARTLINE;
                end
                else if (it.cc != ctlc_pkg::CC_BLANK)
                begin
                    r.gap_v          = (s.span_start != p);
                    r.st.span_start  = p;
                    r.st.open_class  = ctlc_pkg::CL_GAP;
                    r.st.open_prefix = ctlc_pkg::PFX_NONE;
                    r.st.body_start  = '0;
                    if (it.cc == ctlc_pkg::CC_DQUOTE)
                    begin
                        r.st.open_class = ctlc_pkg::CL_STRING;
                        r.st.mode       = M_DQ;
                    end
                    else if (it.cc == ctlc_pkg::CC_SQUOTE)
                    begin
                        r.st.open_class = ctlc_pkg::CL_STRING;
                        r.st.mode       = M_SQ;
                    end
                    else if (it.cc == ctlc_pkg::CC_SLASH)
                    begin
                        r.st.open_class = ctlc_pkg::CL_OPER;
                        r.st.mode       = M_SLASH;
                    end
                    else if (it.annot)
                    begin
                        r.st.mode = M_ANNOT;
                    end
                    else if (it.cc == ctlc_pkg::CC_WORD)
                    begin
                        r.st.open_class = ctlc_pkg::CL_WORD;
                        r.st.body_start = p;
                        r.st.mode       = M_WORD;
                    end
                    else
                    begin
                        r.close_v   = 1'b1;
                        r.close_res = make_res(ctlc_pkg::CL_OPER, p, nxt, '0,
                                               ctlc_pkg::PFX_NONE, 1'b0);
                        r.st        = closed_state(nxt, 1'b0);
                    end
                end
            end
        endcase
        return r;
    endfunction

    assign item_pop = !item_empty && res_room;

    // Two chained passes cover every character that is handled again.
    always_comb
    begin
        pass1 = lex_pass(state_reg, item, pos_reg);
        pass2 = lex_pass(pass1.st, item, pos_reg);
    end

    // Next state and the compacted result pair.
    always_comb
    begin
        logic [1:0] n;
        n              = 2'd0;
        res_wr         = '0;
        state_next     = state_reg;
        pos_next       = pos_reg;
        slot[0]        = pass1.gap_res;
        slot[1]        = pass1.close_res;
        slot[2]        = pass2.gap_res;
        slot[3]        = pass2.close_res;
        slot_v         = {pass1.retry && pass2.close_v, pass1.retry && pass2.gap_v,
                          pass1.close_v, pass1.gap_v};
        if (item.flush)
        begin
            // Flush reports the open span, unless it is an empty gap, as partial and starts a fresh text.
            if (!(state_reg.open_class == ctlc_pkg::CL_GAP && state_reg.span_start == pos_reg))
            begin
                res_wr.res0 = make_res(state_reg.open_class, state_reg.span_start, pos_reg,
                                       state_reg.body_start, state_reg.open_prefix, 1'b1);
                n = 2'd1;
            end
            state_next = STATE_RESET;
            pos_next   = '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (slot_v[i])
                begin
                    if (n == 2'd0)
                    begin
                        res_wr.res0 = slot[i];
                        n           = 2'd1;
                    end
                    else if (n == 2'd1)
                    begin
                        res_wr.res1 = slot[i];
                        n           = 2'd2;
                    end
                end
            end
            state_next = pass1.retry ? pass2.st : pass1.st;
            pos_next   = pos_reg + 1'b1;
        end
        if (n == 2'd1)
        begin
            res_wr.res0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            res_wr.res1.last = 1'b1;
        end
        res_wr.count = item_pop ? n : 2'd0;
    end

    // Lexer state and position counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            pos_reg   <= '0;
        end
        else if (item_pop)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ctlc_result_queue.sv
// ----------------------------------------------------------------------------
// C-like token classifier: result queue
// Takes up to two results a cycle from the lexer, hands out one a cycle on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlc_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctlc_pkg::res_wr_t res_wr,
    output logic                   room,
    input  wire logic              pop,
    output ctlc_pkg::res_t         head,
    output logic                   empty
);

    localparam int unsigned DEPTH = ctlc_pkg::RES_QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ctlc_pkg::res_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_b;
    logic              do_pop;

    assign empty    = (count_reg == '0);
    assign room     = (count_reg <= CNT_W'(DEPTH - 2));
    assign do_pop   = pop && !empty;
    assign head     = entry_reg[rd_ptr_reg];
    assign wr_ptr_b = wr_ptr_reg + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_wr.count);
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(res_wr.count) - CNT_W'(do_pop);
        end
    end

    // Storage: the first result lands at the write pointer, the second after it.
    always_ff @(posedge clk)
    begin
        if (res_wr.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= res_wr.res0;
        end
        if (res_wr.count == 2'd2)
        begin
            entry_reg[wr_ptr_b] <= res_wr.res1;
        end
    end

endmodule

`default_nettype wire

### rtl/c_like_token_classifier_core.sv
// Path: a character accepted into the item queue is taken by the lexer when
// the result queue has room; its spans are registered into the result queue.
// Throughput: one character per cycle while the result queue has room; a
// character that closes two spans has them handed out one at a time.
// Reset: rst_n clears both queues, the lexer to start of line at position
// zero, and the annotation character to '#'.
// ----------------------------------------------------------------------------
// C-like token classifier core
// Streaming lexer for C-like source text: front decoder, item queue, lexer
// and result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "c_like_token_classifier_core_defines.svh"

module c_like_token_classifier_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [ctlc_pkg::CHAR_W-1:0] code_unit,
    input  wire logic                        flush,
    input  wire logic                        annotation_char_we,
    input  wire logic [ctlc_pkg::CHAR_W-1:0] annotation_char,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [2:0]                       token_class,
    output logic [ctlc_pkg::POS_W-1:0]       start_pos,
    output logic [ctlc_pkg::POS_W-1:0]       end_pos,
    output logic [ctlc_pkg::POS_W-1:0]       word_begin,
    output logic [1:0]                       prefix_kind,
    output logic                             partial,
    output logic                             last
);

    ctlc_pkg::item_t   front_item;
    ctlc_pkg::item_t   queue_item;
    logic              item_empty;
    logic              item_pop;
    logic              res_room;
    ctlc_pkg::res_wr_t res_wr;
    ctlc_pkg::res_t    res_head;

    // Front end: annotation register and character decode.
    ctlc_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .annotation_char_we (annotation_char_we),
        .annotation_char    (annotation_char),
        .code_unit          (code_unit),
        .flush              (flush),
        .item               (front_item)
    );

    // Queue of decoded requests.
    ctlc_item_queue u_item_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (front_item),
        .full    (full),
        .pop     (item_pop),
        .rd_item (queue_item),
        .empty   (item_empty)
    );

    // Lexer state machine.
    ctlc_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .res_room   (res_room),
        .res_wr     (res_wr)
    );

    // Queue of finished spans.
    ctlc_result_queue u_result_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .res_wr (res_wr),
        .room   (res_room),
        .pop    (pop),
        .head   (res_head),
        .empty  (empty)
    );

    // Result ports.
    assign token_class = res_head.token_class;
    assign start_pos   = res_head.start_pos;
    assign end_pos     = res_head.end_pos;
    assign word_begin  = res_head.word_begin;
    assign prefix_kind = res_head.prefix_kind;
    assign partial     = res_head.partial;
    assign last        = res_head.last;

    // Checks on the lexer output.
    `CTLC_ASSERT_NOW(a_prefix_only_on_word,
        !empty && prefix_kind != ctlc_pkg::PFX_NONE, token_class == ctlc_pkg::CL_WORD,
        "prefix mark on a span that is not a word")
    `CTLC_ASSERT_NOW(a_word_fields_zero,
        !empty && token_class != ctlc_pkg::CL_WORD, word_begin == '0,
        "word start set on a span that is not a word")
    `CTLC_ASSERT_NOW(a_oper_one_char,
        !empty && token_class == ctlc_pkg::CL_OPER, end_pos == start_pos + 1'b1,
        "operator span longer than one character")
    `CTLC_ASSERT_NEXT(a_no_spurious_result,
        empty && res_wr.count == 2'd0, empty,
        "result appeared without a lexer write")

endmodule

`default_nettype wire

### tb/c_like_token_classifier_core_test.sv
// ----------------------------------------------------------------------------
// C-like token classifier core: self-checking testbench
// Feeds source text one character per request and runs a short directed
// table followed by random fragments of C-like text under several annotation
// characters. Every reported span is checked against a lexer model kept in
// this file or, for some directed rows, a span written by hand. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module c_like_token_classifier_core_test;

    // Characters with a meaning to the lexer.
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_NL     = 16'h000A;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam logic [15:0] CH_SHARP  = 16'h0023;
    localparam logic [15:0] CH_SQUOTE = 16'h0027;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_BSLASH = 16'h005C;

    // Least number of requests per random phase, and the quiet time the block
    // needs before a register write once the last span has come out.
    localparam int PHASE_ITEMS  = 172;
    localparam int IDLE_SETTLE  = 8;
    localparam int HOLD_CYCLES  = 150;

    localparam ctlc_pkg::res_t NO_SPAN = '0;

    // Lexer modes of the model.
    typedef enum logic [3:0] {
        LX_LINE_START,
        LX_ANNOT,
        LX_BLOCK,
        LX_BLOCK_STAR,
        LX_DQ,
        LX_DQ_ESC,
        LX_LINE,
        LX_LINE_ESC,
        LX_NORMAL,
        LX_SQ,
        LX_SQ_ESC,
        LX_SHARP,
        LX_SLASH,
        LX_WORD
    } lex_mode_t;

    // One row of the directed table; typed rows carry their span by hand.
    typedef struct {
        logic [15:0]    cu;
        logic           fl;
        bit             typed;
        int             n;
        ctlc_pkg::res_t span;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [15:0] code_unit;
    logic        flush;
    logic        annot_we;
    logic [15:0] annot_wdata;
    logic        empty;
    logic        pop;
    logic [2:0]  token_class;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [31:0] word_begin;
    logic [1:0]  prefix_kind;
    logic        partial;
    logic        last;

    // Model state.
    lex_mode_t              lx_mode;
    logic [31:0]            lx_pos;
    logic [31:0]            lx_span;
    logic [31:0]            lx_body;
    ctlc_pkg::token_class_t lx_cls;
    ctlc_pkg::prefix_t      lx_pfx;
    logic [15:0]            lx_annot;

    ctlc_pkg::res_t step_spans[$];
    ctlc_pkg::res_t pending_spans[$];
    stim_row_t      stim_rows[$];
    int        error_count = 0;
    int        items_sent  = 0;
    int        burst_left  = 0;
    string     punct_set   = "+-(){};,.|~!=<>[]%&^?:";
    logic [15:0] annot_plan[9] = '{16'h0040, 16'hFFFF, 16'h0000, 16'h002F, 16'h0022,
                                  16'h0027, 16'h0061, 16'h0000, 16'h0023};

    c_like_token_classifier_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .code_unit          (code_unit),
        .flush              (flush),
        .annotation_char_we (annot_we),
        .annotation_char    (annot_wdata),
        .empty              (empty),
        .pop                (pop),
        .token_class        (token_class),
        .start_pos          (start_pos),
        .end_pos            (end_pos),
        .word_begin         (word_begin),
        .prefix_kind        (prefix_kind),
        .partial            (partial),
        .last               (last)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------

    function automatic bit is_ident_char(logic [15:0] c);
        return (c >= 16'h0030 && c <= 16'h0039) || (c >= 16'h0041 && c <= 16'h005A) ||
               (c >= 16'h0061 && c <= 16'h007A) || c == 16'h005F || c >= 16'h0080;
    endfunction

    function automatic void lex_clear();
        lx_mode = LX_LINE_START;
        lx_pos  = '0;
        lx_span = '0;
        lx_body = '0;
        lx_cls  = ctlc_pkg::CL_GAP;
        lx_pfx  = ctlc_pkg::PFX_NONE;
    endfunction

    // Records one span; the body start and prefix only mean something for words.
    function automatic void report_span(ctlc_pkg::token_class_t cls, logic [31:0] s,
                                        logic [31:0] e, logic part);
        ctlc_pkg::res_t r;
        r.token_class = cls;
        r.start_pos   = s;
        r.end_pos     = e;
        r.word_begin  = (cls == ctlc_pkg::CL_WORD) ? lx_body : '0;
        r.prefix_kind = (cls == ctlc_pkg::CL_WORD) ? lx_pfx : ctlc_pkg::PFX_NONE;
        r.partial     = part;
        r.last        = 1'b0;
        if (step_spans.size() < 2)
            step_spans.push_back(r);
    endfunction

    // Empty gaps are never reported.
    function automatic void gap_before(logic [31:0] p);
        if (lx_span != p)
            report_span(ctlc_pkg::CL_GAP, lx_span, p, 1'b0);
        lx_span = p;
    endfunction

    function automatic void drop_to_gap();
        lx_cls  = ctlc_pkg::CL_GAP;
        lx_pfx  = ctlc_pkg::PFX_NONE;
        lx_body = '0;
    endfunction

    function automatic void close_open(logic [31:0] e, logic [15:0] c);
        report_span(lx_cls, lx_span, e, 1'b0);
        lx_span = e;
        drop_to_gap();
        lx_mode = (c == CH_NL) ? LX_LINE_START : LX_NORMAL;
    endfunction

    // Handles one character; a 1 back means the character must be seen again.
    function automatic bit lex_char(logic [15:0] c, logic [31:0] p);
        logic [31:0] nxt;
        nxt = p + 32'd1;
        case (lx_mode)
            LX_LINE_START:
            begin
                if (c == CH_TAB || c == CH_NL || c == CH_SPACE)
                    return 1'b0;
                if (c == CH_SHARP)
                begin
                    gap_before(p);
                    lx_cls  = ctlc_pkg::CL_WORD;
                    lx_pfx  = ctlc_pkg::PFX_SHARP;
                    lx_body = nxt;
                    lx_mode = LX_SHARP;
                    return 1'b0;
                end
                lx_mode = LX_NORMAL;
                return 1'b1;
            end
            LX_ANNOT:
            begin
                if (is_ident_char(c))
                begin
                    lx_cls  = ctlc_pkg::CL_WORD;
                    lx_pfx  = ctlc_pkg::PFX_ANNOT;
                    lx_body = p;
                    lx_mode = LX_WORD;
                    return 1'b0;
                end
                lx_mode = LX_NORMAL;
                return 1'b1;
            end
            LX_BLOCK:
            begin
                if (c == CH_STAR)
                    lx_mode = LX_BLOCK_STAR;
                return 1'b0;
            end
            LX_BLOCK_STAR:
            begin
                if (c == CH_SLASH)
                    close_open(nxt, c);
                else if (c != CH_STAR)
                    lx_mode = LX_BLOCK;
                return 1'b0;
            end
            LX_DQ:
            begin
                if (c == CH_DQUOTE)
                    close_open(nxt, c);
                else if (c == CH_BSLASH)
                    lx_mode = LX_DQ_ESC;
                return 1'b0;
            end
            LX_DQ_ESC:
            begin
                lx_mode = LX_DQ;
                return 1'b0;
            end
            LX_SQ:
            begin
                if (c == CH_SQUOTE)
                    close_open(nxt, c);
                else if (c == CH_BSLASH)
                    lx_mode = LX_SQ_ESC;
                return 1'b0;
            end
            LX_SQ_ESC:
            begin
                lx_mode = LX_SQ;
                return 1'b0;
            end
            LX_LINE:
            begin
                if (c == CH_NL)
                begin
                    close_open(p, c);
                    return 1'b1;
                end
                if (c == CH_BSLASH)
                    lx_mode = LX_LINE_ESC;
                return 1'b0;
            end
            LX_LINE_ESC:
            begin
                lx_mode = LX_LINE;
                return 1'b0;
            end
            LX_SHARP:
            begin
                if (c == CH_NL)
                begin
                    drop_to_gap();
                    lx_mode = LX_LINE_START;
                end
                else if (c == CH_TAB || c == CH_SPACE)
                begin
                    // Blanks after the sharp are swallowed.
                end
                else if (is_ident_char(c))
                begin
                    lx_body = p;
                    lx_mode = LX_WORD;
                end
                else
                begin
                    drop_to_gap();
                    lx_mode = LX_NORMAL;
                end
                return 1'b0;
            end
            LX_SLASH:
            begin
                if (c == CH_SLASH || c == CH_STAR)
                begin
                    lx_cls  = ctlc_pkg::CL_COMMENT;
                    lx_mode = (c == CH_SLASH) ? LX_LINE : LX_BLOCK;
                    return 1'b0;
                end
                close_open(p, c);
                return 1'b1;
            end
            LX_WORD:
            begin
                if (is_ident_char(c))
                    return 1'b0;
                close_open(p, c);
                return 1'b1;
            end
            default: ;
        endcase

        // Normal mode: quotes and slash win over the annotation character.
        if (c == CH_NL)
        begin
            lx_mode = LX_LINE_START;
            return 1'b0;
        end
        if (c == CH_TAB || c == CH_SPACE)
            return 1'b0;
        gap_before(p);
        drop_to_gap();
        if (c == CH_DQUOTE)
        begin
            lx_cls  = ctlc_pkg::CL_STRING;
            lx_mode = LX_DQ;
        end
        else if (c == CH_SQUOTE)
        begin
            lx_cls  = ctlc_pkg::CL_STRING;
            lx_mode = LX_SQ;
        end
        else if (c == CH_SLASH)
        begin
            lx_cls  = ctlc_pkg::CL_OPER;
            lx_mode = LX_SLASH;
        end
        else if (c == lx_annot)
            lx_mode = LX_ANNOT;
        else if (is_ident_char(c))
        begin
            lx_cls  = ctlc_pkg::CL_WORD;
            lx_body = p;
            lx_mode = LX_WORD;
        end
        else
        begin
            lx_cls = ctlc_pkg::CL_OPER;
            close_open(nxt, c);
        end
        return 1'b0;
    endfunction

    // Works out the spans that one accepted request gives, into step_spans.
    function automatic void lex_step(logic [15:0] c, logic fl);
        step_spans.delete();
        if (fl)
        begin
            if (!(lx_cls == ctlc_pkg::CL_GAP && lx_span == lx_pos))
                report_span(lx_cls, lx_span, lx_pos, 1'b1);
            lex_clear();
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                if (!lex_char(c, lx_pos))
                    break;
            lx_pos = lx_pos + 32'd1;
        end
        if (step_spans.size() > 0)
            step_spans[step_spans.size() - 1].last = 1'b1;
    endfunction

    function automatic void commit_spans();
        foreach (step_spans[k])
            pending_spans.push_back(step_spans[k]);
    endfunction

    function automatic stim_row_t row(logic [15:0] cu, logic fl, bit typed, int n,
                                      ctlc_pkg::res_t span);
        stim_row_t r;
        r.cu    = cu;
        r.fl    = fl;
        r.typed = typed;
        r.n     = n;
        r.span  = span;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------------

    function automatic logic [15:0] punct_chr();
        return {8'h00, punct_set[$urandom_range(punct_set.len() - 1, 0)]};
    endfunction

    function automatic logic [15:0] word_chr();
        case ($urandom_range(4, 0))
            0:       return 16'($urandom_range(16'h005A, 16'h0041));
            1:       return 16'($urandom_range(16'h0039, 16'h0030));
            2:       return 16'h005F;
            3:       return 16'($urandom_range(16'hFFFF, 16'h0080));
            default: return 16'($urandom_range(16'h007A, 16'h0061));
        endcase
    endfunction

    // Filler for strings and comments.
    function automatic logic [15:0] body_chr();
        case ($urandom_range(5, 0))
            0:       return CH_SPACE;
            1:       return punct_chr();
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return 16'($urandom_range(16'hFFFF, 16'h0080));
            default: return 16'($urandom_range(16'h007A, 16'h0061));
        endcase
    endfunction

    // Any character, weighted towards the ones that steer the lexer.
    function automatic logic [15:0] any_chr();
        case ($urandom_range(13, 0))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NL;
            3:       return CH_SHARP;
            4:       return CH_SLASH;
            5:       return CH_STAR;
            6:       return CH_DQUOTE;
            7:       return CH_SQUOTE;
            8:       return CH_BSLASH;
            9:       return lx_annot;
            10:      return punct_chr();
            11:      return 16'($urandom_range(16'hFFFF, 0));
            default: return word_chr();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request in bursts with random gaps, and models it once taken.
    task automatic send(logic [15:0] cu, logic fl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push      <= 1'b1;
        code_unit <= cu;
        flush     <= fl;
        @(posedge clk);
        while (full)
            @(posedge clk);
        lex_step(cu, fl);
    endtask

    task automatic put(logic [15:0] cu, logic fl);
        send(cu, fl);
        commit_spans();
        items_sent++;
    endtask

    // Stops offering until every span is out and the block has gone quiet.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // One fragment of C-like text, mostly well formed.
    task automatic put_fragment();
        int pick;
        int k;
        pick = $urandom_range(99, 0);
        if (pick < 18)
        begin
            repeat ($urandom_range(6, 1)) put(word_chr(), 1'b0);
        end
        else if (pick < 28)
        begin
            repeat ($urandom_range(3, 1)) put($urandom_range(1, 0) ? CH_SPACE : CH_TAB, 1'b0);
        end
        else if (pick < 35)
            put(CH_NL, 1'b0);
        else if (pick < 43)
        begin
            // Directive at the start of a line.
            put(CH_NL, 1'b0);
            if ($urandom_range(2, 0) == 0)
                put(CH_SPACE, 1'b0);
            put(CH_SHARP, 1'b0);
            repeat ($urandom_range(2, 0)) put($urandom_range(1, 0) ? CH_SPACE : CH_TAB, 1'b0);
            k = $urandom_range(3, 0);
            if (k == 0)
                put(CH_NL, 1'b0);
            else if (k == 1)
                put(punct_chr(), 1'b0);
            else
                repeat ($urandom_range(5, 1)) put(word_chr(), 1'b0);
        end
        else if (pick < 51)
        begin
            // Annotation, with or without a word behind it.
            put(lx_annot, 1'b0);
            if ($urandom_range(3, 0) != 0)
                repeat ($urandom_range(4, 1)) put(word_chr(), 1'b0);
            else
                put(any_chr(), 1'b0);
        end
        else if (pick < 64)
        begin
            // Quoted string with escapes; now and then left open.
            k = (pick < 59) ? CH_DQUOTE : CH_SQUOTE;
            put(16'(k), 1'b0);
            repeat ($urandom_range(6, 0))
            begin
                if ($urandom_range(5, 0) == 0)
                begin
                    put(CH_BSLASH, 1'b0);
                    put(any_chr(), 1'b0);
                end
                else
                    put(($urandom_range(9, 0) == 0) ? CH_NL : body_chr(), 1'b0);
            end
            if ($urandom_range(9, 0) != 0)
                put(16'(k), 1'b0);
        end
        else if (pick < 71)
        begin
            // Line comment with backslash continuations.
            put(CH_SLASH, 1'b0);
            put(CH_SLASH, 1'b0);
            repeat ($urandom_range(6, 0))
            begin
                if ($urandom_range(5, 0) == 0)
                begin
                    put(CH_BSLASH, 1'b0);
                    put(($urandom_range(1, 0) == 0) ? CH_NL : any_chr(), 1'b0);
                end
                else
                    put(body_chr(), 1'b0);
            end
            put(CH_NL, 1'b0);
        end
        else if (pick < 77)
        begin
            // Block comment.
            put(CH_SLASH, 1'b0);
            put(CH_STAR, 1'b0);
            repeat ($urandom_range(6, 0)) put(($urandom_range(7, 0) == 0) ? CH_NL : body_chr(),
                                              1'b0);
            repeat ($urandom_range(2, 1)) put(CH_STAR, 1'b0);
            put(CH_SLASH, 1'b0);
        end
        else if (pick < 85)
        begin
            // Operators, including a lone slash.
            if ($urandom_range(2, 0) == 0)
            begin
                put(CH_SLASH, 1'b0);
                put($urandom_range(1, 0) ? punct_chr() : word_chr(), 1'b0);
            end
            else
                put(punct_chr(), 1'b0);
        end
        else if (pick < 98)
        begin
            repeat ($urandom_range(4, 1)) put(any_chr(), 1'b0);
        end
        else
            put(16'($urandom_range(16'hFFFF, 0)), 1'b1);
    endtask

    // Reset, directed table, then the random phases.
    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        code_unit   = '0;
        flush       = 1'b0;
        annot_we    = 1'b0;
        annot_wdata = ctlc_pkg::ANNOT_RESET;
        lx_annot    = ctlc_pkg::ANNOT_RESET;
        lex_clear();

        // Directed text under the reset annotation character.
        stim_rows.push_back(row(16'h0000, 1'b1, 1'b1, 0, NO_SPAN));   // nothing open
        stim_rows.push_back(row(CH_SPACE, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_SHARP, 1'b0, 1'b1, 1,
                                '{ctlc_pkg::CL_GAP, 32'd0, 32'd1, 32'd0,
                                  ctlc_pkg::PFX_NONE, 1'b0, 1'b1}));
        stim_rows.push_back(row(CH_SPACE, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(16'h0069, 1'b0, 1'b0, 0, NO_SPAN));   // 'i'
        stim_rows.push_back(row(CH_NL, 1'b0, 1'b1, 1,
                                '{ctlc_pkg::CL_WORD, 32'd1, 32'd4, 32'd3,
                                  ctlc_pkg::PFX_SHARP, 1'b0, 1'b1}));
        stim_rows.push_back(row(CH_SHARP, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_NL, 1'b0, 1'b0, 0, NO_SPAN));      // sharp then newline
        stim_rows.push_back(row(CH_SHARP, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(16'h002B, 1'b0, 1'b0, 0, NO_SPAN));   // sharp then '+'
        stim_rows.push_back(row(CH_SLASH, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_SLASH, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_BSLASH, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_NL, 1'b0, 1'b0, 0, NO_SPAN));      // escaped newline
        stim_rows.push_back(row(CH_NL, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_SLASH, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_STAR, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_STAR, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_SLASH, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_DQUOTE, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(CH_DQUOTE, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(16'hFFFF, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(16'h0000, 1'b0, 1'b0, 0, NO_SPAN));   // closes two spans
        stim_rows.push_back(row(CH_SHARP, 1'b0, 1'b0, 0, NO_SPAN));   // annotation
        stim_rows.push_back(row(16'h0061, 1'b0, 1'b0, 0, NO_SPAN));   // 'a'
        stim_rows.push_back(row(CH_SQUOTE, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(16'h0000, 1'b1, 1'b1, 1,
                                '{ctlc_pkg::CL_STRING, 32'd24, 32'd25, 32'd0,
                                  ctlc_pkg::PFX_NONE, 1'b1, 1'b1}));
        stim_rows.push_back(row(CH_SLASH, 1'b0, 1'b0, 0, NO_SPAN));
        stim_rows.push_back(row(16'h0078, 1'b0, 1'b0, 0, NO_SPAN));   // lone slash ends at 'x'

        annot_plan[7] = 16'($urandom_range(16'hFFFF, 0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            send(stim_rows[i].cu, stim_rows[i].fl);
            if (!stim_rows[i].typed)
                commit_spans();
            else if (stim_rows[i].n == 1)
                pending_spans.push_back(stim_rows[i].span);
        end

        // Random phases, each under its own annotation character.
        foreach (annot_plan[ph])
        begin
            wait_idle();
            @(negedge clk);
            annot_we    <= 1'b1;
            annot_wdata <= annot_plan[ph];
            @(negedge clk);
            annot_we <= 1'b0;
            lx_annot = annot_plan[ph];
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                put_fragment();
        end

        wait_idle();
        if (error_count == 0)
            $display("c_like_token_classifier_core_test: done, clean");
        else
            $display("c_like_token_classifier_core_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The receiver stalls on a pattern of its own, with a long hold-off now
    // and then so that the block fills up and refuses requests.
    initial
    begin
        int seg;
        int pct;
        pop = 1'b0;
        seg = 0;
        @(posedge rst_n);
        forever
        begin
            seg++;
            if (seg % 12 == 3)
            begin
                @(negedge clk);
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                case ($urandom_range(3, 0))
                    0:       pct = 100;
                    1:       pct = 70;
                    2:       pct = 35;
                    default: pct = 10;
                endcase
                repeat ($urandom_range(60, 5))
                begin
                    @(negedge clk);
                    pop <= ($urandom_range(99, 0) < pct);
                end
            end
        end
    end

    // Each span taken is compared with the oldest one the model expects.
    always @(posedge clk)
    begin : check_spans
        ctlc_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_spans.size() == 0)
            begin
                $error("span [%0d, %0d) came out with none expected", start_pos, end_pos);
                error_count++;
            end
            else
            begin
                want = pending_spans.pop_front();
                if (token_class !== want.token_class)
                begin
                    $error("token_class: expected %0d, got %0d", want.token_class, token_class);
                    error_count++;
                end
                if (start_pos !== want.start_pos)
                begin
                    $error("start_pos: expected %0d, got %0d", want.start_pos, start_pos);
                    error_count++;
                end
                if (end_pos !== want.end_pos)
                begin
                    $error("end_pos: expected %0d, got %0d", want.end_pos, end_pos);
                    error_count++;
                end
                if (word_begin !== want.word_begin)
                begin
                    $error("word_begin: expected %0d, got %0d", want.word_begin, word_begin);
                    error_count++;
                end
                if (prefix_kind !== want.prefix_kind)
                begin
                    $error("prefix_kind: expected %0d, got %0d", want.prefix_kind, prefix_kind);
                    error_count++;
                end
                if (partial !== want.partial)
                begin
                    $error("partial: expected %0d, got %0d", want.partial, partial);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("c_like_token_classifier_core_test: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ctlc_pkg.sv
rtl/ctlc_front.sv
rtl/ctlc_item_queue.sv
rtl/ctlc_lexer.sv
rtl/ctlc_result_queue.sv
rtl/c_like_token_classifier_core.sv
tb/c_like_token_classifier_core_test.sv
